// ----- rtl/core/rbm_pkg.sv -----
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants for the ROM bank mapper with bit-reverse flag.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int RAM_BYTES   = 8192;
  localparam int RAM_AW      = $clog2(RAM_BYTES);
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ROM_AW      = 21;
  localparam int PAGE_W      = 7;   // largest page is 2*63+1
  localparam int PAGE_OFS_W  = 13;  // 8KB page
  localparam int SLOTS       = 4;
  localparam int SLOT_W      = 2;

  localparam logic             FUNC_READ   = 1'b0;
  localparam logic             FUNC_WRITE  = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_SLOT0   = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT1   = 16'h6000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT2   = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_SLOT3   = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_BANKED  = 16'h4000;
  localparam logic [ADDR_W-1:0] ADDR_RAM     = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_PAIR_LO = 16'hFFFE;
  localparam logic [ADDR_W-1:0] ADDR_PAIR_HI = 16'hFFFF;
  localparam logic [DATA_W-1:0] PAGE_MASK    = 8'h3F;
  localparam int                REV_BIT      = 6;

  // Decode of one access, carried from the bank block to the output stage
  typedef struct packed {
    logic              from_rom;
    logic [ROM_AW-1:0] rom_address;
    logic              reverse_rom;
    logic              ram_read;
    logic              ram_write;
    logic [RAM_AW-1:0] ram_addr;
  } rbm_map_t;

  typedef logic [PAGE_W-1:0] rbm_page_t;

endpackage

// ----- rtl/core/rbm_if.sv -----
// ----------------------------------------------------------------------------
// rbm_req_if / rbm_rsp_if
// Valid/ready channels for bus accesses and their mapping results.
// ----------------------------------------------------------------------------
interface rbm_req_if import rbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output func, output address, output write_data,
                  input ready);
  modport sink   (input valid, input func, input address, input write_data,
                  output ready);
endinterface

interface rbm_rsp_if import rbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              from_rom;
  logic [ROM_AW-1:0] rom_address;
  logic              reverse_rom;
  logic [DATA_W-1:0] ram_data;
  logic [DATA_W-1:0] bank_zero;
  logic [DATA_W-1:0] bank_one;
  logic [DATA_W-1:0] bank_two;
  logic [DATA_W-1:0] bank_three;

  modport source (output valid, output from_rom, output rom_address,
                  output reverse_rom, output ram_data, output bank_zero,
                  output bank_one, output bank_two, output bank_three,
                  input ready);
  modport sink   (input valid, input from_rom, input rom_address,
                  input reverse_rom, input ram_data, input bank_zero,
                  input bank_one, input bank_two, input bank_three,
                  output ready);
endinterface

// ----- rtl/core/rom_bank_mapper_with_bit_reverse.sv -----
// ----------------------------------------------------------------------------
// rom_bank_mapper_with_bit_reverse
// ROM bank mapper with 8KB pages, bit-reverse flags and mirrored work RAM.
// ----------------------------------------------------------------------------
// An access's result is registered and shows on rsp in the cycle after its transfer.
// Throughput: one access per cycle while rsp is ready; a stalled result holds off new accesses.
// A write's RAM update lands at its transfer edge, so a read in the next
// cycle already sees it.
// Reset (rst, synchronous): pages 0,2,4,6 mapped, bank numbers 0..3, reverse
// flags clear, output stage empty. Work RAM is not cleared.
// ----------------------------------------------------------------------------
module rom_bank_mapper_with_bit_reverse import rbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rbm_req_if.sink   req,
  rbm_rsp_if.source rsp
);

  logic              accept;
  rbm_map_t          map;
  rbm_page_t         number_next [SLOTS];
  logic [DATA_W-1:0] rdata;

  // Output stage registers
  logic              valid;
  logic              from_rom;
  logic [ROM_AW-1:0] rom_address;
  logic              reverse_rom;
  logic              ram_read;
  rbm_page_t         bank [SLOTS];

  // Take a new access whenever the output stage is empty or being drained
  assign req.ready = !valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Page registers and decode; pages update at the transfer edge
  rbm_banks u_banks (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (req.func),
    .address    (req.address),
    .write_data (req.write_data),
    .map        (map),
    .number_next(number_next)
  );

  // Work RAM, mirrored every 8KB above 0xC000; read data is the output register
  rbm_wram u_wram (
    .clk  (clk),
    .we   (accept && map.ram_write),
    .re   (accept && map.ram_read),
    .addr (map.ram_addr),
    .wdata(req.write_data),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // Hold the payload while the result stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      from_rom    <= map.from_rom;
      rom_address <= map.rom_address;
      reverse_rom <= map.reverse_rom;
      ram_read    <= map.ram_read;
      for (int i = 0; i < SLOTS; i++) begin
        bank[i] <= number_next[i];
      end
    end
  end

  assign rsp.valid       = valid;
  assign rsp.from_rom    = from_rom;
  assign rsp.rom_address = rom_address;
  assign rsp.reverse_rom = reverse_rom;
  assign rsp.ram_data    = ram_read ? rdata : '0;
  assign rsp.bank_zero   = DATA_W'(bank[0]);
  assign rsp.bank_one    = DATA_W'(bank[1]);
  assign rsp.bank_two    = DATA_W'(bank[2]);
  assign rsp.bank_three  = DATA_W'(bank[3]);

endmodule

// ----- rtl/core/rbm_wram.sv -----
// ----------------------------------------------------------------------------
// rbm_wram
// Work RAM, single port, registered read.
// ----------------------------------------------------------------------------
module rbm_wram import rbm_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [RAM_AW-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [RAM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data while the result stalls
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/rbm_banks.sv -----
// ----------------------------------------------------------------------------
// rbm_banks
// Bank page registers, reverse flags and address decode of one access.
// ----------------------------------------------------------------------------
module rbm_banks import rbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              func,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output rbm_map_t          map,
  output rbm_page_t         number_next [SLOTS]
);

  rbm_page_t offset      [SLOTS];
  rbm_page_t number      [SLOTS];
  rbm_page_t offset_next [SLOTS];
  logic      rev         [2];
  logic      rev_next    [2];

  logic [PAGE_W-2:0] sel;
  logic [SLOT_W-1:0] slot;
  logic              is_wr;

  assign sel   = write_data[PAGE_W-2:0];
  assign is_wr = accept && (func == FUNC_WRITE);

  // Next page state after this access
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      offset_next[i] = offset[i];
      number_next[i] = number[i];
    end
    rev_next[0] = rev[0];
    rev_next[1] = rev[1];
    if (is_wr) begin
      case (address)
        ADDR_SLOT0: begin
          offset_next[0] = {1'b0, sel};
          number_next[0] = {1'b0, sel};
        end
        ADDR_SLOT1: begin
          offset_next[1] = {1'b0, sel};
          number_next[1] = {1'b0, sel};
        end
        ADDR_SLOT2: begin
          offset_next[2] = {1'b0, sel};
          number_next[2] = {1'b0, sel};
        end
        ADDR_SLOT3: begin
          offset_next[3] = {1'b0, sel};
          number_next[3] = {1'b0, sel};
        end
        ADDR_PAIR_LO: begin
          offset_next[0] = {sel, 1'b0};
          number_next[0] = {sel, 1'b0};
          offset_next[1] = {sel, 1'b1};
          number_next[1] = {sel, 1'b1};
          rev_next[0]    = write_data[REV_BIT];
        end
        ADDR_PAIR_HI: begin
          offset_next[2] = {sel, 1'b0};
          number_next[2] = {sel, 1'b0};
          offset_next[3] = {sel, 1'b1};
          number_next[3] = {sel, 1'b1};
          rev_next[1]    = write_data[REV_BIT];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        offset[i] <= PAGE_W'(2 * i);
        number[i] <= PAGE_W'(i);
      end
      rev[0] <= 1'b0;
      rev[1] <= 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        offset[i] <= offset_next[i];
        number[i] <= number_next[i];
      end
      rev[0] <= rev_next[0];
      rev[1] <= rev_next[1];
    end
  end

  // Slot of a banked read: address[15:13] runs 2..5
  assign slot = SLOT_W'(address[ADDR_W-1:PAGE_OFS_W] - 3'd2);

  always_comb begin
    map             = '0;
    map.ram_addr    = address[RAM_AW-1:0];
    if (func == FUNC_READ) begin
      if (address < ADDR_BANKED) begin
        map.from_rom    = 1'b1;
        map.rom_address = ROM_AW'(address);
      end else if (address < ADDR_RAM) begin
        map.from_rom    = 1'b1;
        map.rom_address = ROM_AW'({offset[slot], address[PAGE_OFS_W-1:0]});
        map.reverse_rom = rev[address[ADDR_W-1]];
      end else begin
        map.ram_read    = 1'b1;
      end
    end else begin
      map.ram_write = (address >= ADDR_RAM);
    end
  end

endmodule
